// ===== rtl/dmpct_pkg.sv =====
// Shared types and constants for the direct-mapped page cache tag controller.
`default_nettype none

package dmpct_pkg;

	localparam int DMPCT_LINES  = 64;
	localparam int DMPCT_PAGE_W = 32;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_APPEND = 2'd2
	} op_t;

	typedef struct packed {
		logic                    valid;
		logic                    dirty;
		logic [DMPCT_PAGE_W-1:0] tag;
	} line_t;

endpackage

`default_nettype wire

// ===== rtl/dmpct_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module dmpct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_page_cache_tags_core.sv =====
// Top level of the direct-mapped write-back page cache tag and control logic.
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    opcode, page_number
// out       source     out_valid / out_stall  status, hit, fetch_needed, evict_writeback,
//                                             evict_page, target_page, page_count_now,
//                                             read_count, write_count, append_count,
//                                             hit_total, miss_total
// cfg       sink       cfg_valid / cfg_ready  pages_at_open
//
// One access is accepted every cycle while the input is not stalled. The transfer loads the
// divide stage, the tag RAM is then read into the second stage and the result register is
// loaded after that; a stall holds these steps.
// After reset the tag RAM is cleared one line per cycle, so inputs stall until every line
// is cleared. A configuration write holds the input while the line of the running page
// count is worked out. A stalled output stalls the pipeline behind it.
`default_nettype none

module direct_mapped_page_cache_tags_core
	import dmpct_pkg::*;
#(
	parameter int CACHE_LINES = DMPCT_LINES
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [DMPCT_PAGE_W-1:0] pages_at_open,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              opcode,
	input  wire logic [DMPCT_PAGE_W-1:0] page_number,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         status,
	output logic                         hit,
	output logic                         fetch_needed,
	output logic                         evict_writeback,
	output logic [DMPCT_PAGE_W-1:0]      evict_page,
	output logic [DMPCT_PAGE_W-1:0]      target_page,
	output logic [DMPCT_PAGE_W-1:0]      page_count_now,
	output logic [DMPCT_PAGE_W-1:0]      read_count,
	output logic [DMPCT_PAGE_W-1:0]      write_count,
	output logic [DMPCT_PAGE_W-1:0]      append_count,
	output logic [DMPCT_PAGE_W-1:0]      hit_total,
	output logic [DMPCT_PAGE_W-1:0]      miss_total
);

	localparam int IDX_W = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
	localparam int SHIFT = DMPCT_PAGE_W + $clog2(CACHE_LINES);
	localparam logic [64:0] RECIP_W =
		((65'd1 << SHIFT) + 65'(CACHE_LINES) - 65'd1) / 65'(CACHE_LINES);
	localparam logic [32:0] RECIP = RECIP_W[32:0];
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_LINES - 1);

	// The rounded-up reciprocal gives the exact quotient for every 32-bit page number.
	function automatic logic [IDX_W-1:0] line_of(input logic [64:0] prod,
		input logic [DMPCT_PAGE_W-1:0] n);
		logic [DMPCT_PAGE_W-1:0] q;
		logic [DMPCT_PAGE_W-1:0] r;
		q = DMPCT_PAGE_W'(prod >> SHIFT);
		r = n - DMPCT_PAGE_W'(q * DMPCT_PAGE_W'(CACHE_LINES));
		return r[IDX_W-1:0];
	endfunction

	logic                    valid_s1;
	logic [1:0]              op_s1;
	logic [DMPCT_PAGE_W-1:0] page_s1;
	logic [64:0]             prod_s1;

	logic                    valid_s2;
	logic [1:0]              op_s2;
	logic [DMPCT_PAGE_W-1:0] page_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic                    fwd_s2;
	line_t                   fwd_line_s2;

	logic [DMPCT_PAGE_W-1:0] page_total_q;
	logic [DMPCT_PAGE_W-1:0] reads_q;
	logic [DMPCT_PAGE_W-1:0] writes_q;
	logic [DMPCT_PAGE_W-1:0] appends_q;
	logic [DMPCT_PAGE_W-1:0] hits_q;
	logic [DMPCT_PAGE_W-1:0] misses_q;
	logic [IDX_W-1:0]        pt_idx_q;
	logic                    pt_pend_q;
	logic [64:0]             pt_prod_q;
	logic                    clr_q;
	logic [IDX_W-1:0]        clr_cnt_q;

	logic                    out_valid_q;
	logic                    status_q;
	logic                    hit_q;
	logic                    fetch_q;
	logic                    wb_q;
	logic [DMPCT_PAGE_W-1:0] evict_page_q;
	logic [DMPCT_PAGE_W-1:0] target_q;

	logic                    adv_s2;
	logic                    adv_s1;
	logic                    in_acc;
	logic                    cfg_acc;
	logic [IDX_W-1:0]        pt_idx_d;
	logic [IDX_W-1:0]        addr_s1;

	logic [$bits(line_t)-1:0] rdata;
	line_t                    line_cur;
	line_t                    new_line;
	logic                     fill;
	logic                     fill_dirty;
	logic [DMPCT_PAGE_W-1:0]  fill_page;
	logic                     st;
	logic                     h;
	logic                     fetch;
	logic                     wb;
	logic [DMPCT_PAGE_W-1:0]  tgt;
	logic                     inc_read;
	logic                     inc_write;
	logic                     inc_append;
	logic                     inc_hit;
	logic                     inc_miss;
	logic                     in_range;
	logic                     we_s2;

	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [$bits(line_t)-1:0] ram_wdata;

	assign adv_s2    = valid_s2 && (!out_valid_q || !out_stall);
	assign adv_s1    = valid_s1 && (!valid_s2 || adv_s2);
	assign in_stall  = clr_q || pt_pend_q || (valid_s1 && !adv_s1);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = !pt_pend_q;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign line_cur = fwd_s2 ? fwd_line_s2 : line_t'(rdata);
	assign in_range = page_s2 < page_total_q;

	always_comb begin
		fill       = 1'b0;
		fill_dirty = 1'b0;
		fill_page  = page_s2;
		st         = 1'b0;
		h          = 1'b0;
		fetch      = 1'b0;
		tgt        = page_s2;
		inc_read   = 1'b0;
		inc_write  = 1'b0;
		inc_append = 1'b0;
		inc_hit    = 1'b0;
		inc_miss   = 1'b0;
		case (op_t'(op_s2))
			OP_READ: begin
				if (line_cur.valid && line_cur.tag == page_s2) begin
					h        = 1'b1;
					inc_hit  = 1'b1;
					inc_read = 1'b1;
				end else begin
					inc_miss = 1'b1;
					if (in_range) begin
						inc_read = 1'b1;
						fetch    = 1'b1;
						fill     = 1'b1;
					end else begin
						st = 1'b1;
					end
				end
			end
			OP_WRITE: begin
				if (in_range) begin
					inc_write  = 1'b1;
					fill       = 1'b1;
					fill_dirty = 1'b1;
				end else begin
					st = 1'b1;
				end
			end
			OP_APPEND: begin
				fill       = 1'b1;
				fill_page  = page_total_q;
				tgt        = page_total_q;
				inc_append = 1'b1;
			end
			default: begin
			end
		endcase
		wb = fill && line_cur.valid && line_cur.dirty && line_cur.tag != fill_page;
	end

	assign new_line = '{valid: 1'b1, dirty: fill_dirty, tag: fill_page};
	assign we_s2    = adv_s2 && fill;

	always_comb begin
		pt_idx_d = pt_idx_q;
		if (adv_s2 && op_s2 == OP_APPEND) begin
			if (page_total_q == '1 || pt_idx_q == LAST_IDX) begin
				pt_idx_d = '0;
			end else begin
				pt_idx_d = pt_idx_q + IDX_W'(1);
			end
		end
	end

	assign addr_s1 = (op_s1 == OP_APPEND) ? pt_idx_d : line_of(prod_s1, page_s1);

	assign ram_we    = clr_q || we_s2;
	assign ram_waddr = clr_q ? clr_cnt_q : idx_s2;
	assign ram_wdata = clr_q ? '0 : new_line;

	dmpct_ram #(
		.WIDTH ($bits(line_t)),
		.DEPTH (CACHE_LINES),
		.AW    (IDX_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv_s1),
		.raddr (addr_s1),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			fwd_s2       <= 1'b0;
			out_valid_q  <= 1'b0;
			page_total_q <= '0;
			reads_q      <= '0;
			writes_q     <= '0;
			appends_q    <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			pt_idx_q     <= '0;
			pt_pend_q    <= 1'b0;
			clr_q        <= 1'b1;
			clr_cnt_q    <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
				if (clr_cnt_q == LAST_IDX) begin
					clr_q <= 1'b0;
				end
			end

			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1) begin
				valid_s2 <= 1'b1;
				fwd_s2   <= we_s2 && idx_s2 == addr_s1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end

			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_acc) begin
				page_total_q <= pages_at_open;
				pt_pend_q    <= 1'b1;
			end else if (pt_pend_q) begin
				pt_idx_q  <= line_of(pt_prod_q, page_total_q);
				pt_pend_q <= 1'b0;
			end else begin
				pt_idx_q <= pt_idx_d;
				if (adv_s2 && inc_append) begin
					page_total_q <= page_total_q + DMPCT_PAGE_W'(1);
				end
			end

			if (adv_s2) begin
				if (inc_read) begin
					reads_q <= reads_q + DMPCT_PAGE_W'(1);
				end
				if (inc_write) begin
					writes_q <= writes_q + DMPCT_PAGE_W'(1);
				end
				if (inc_append) begin
					appends_q <= appends_q + DMPCT_PAGE_W'(1);
				end
				if (inc_hit) begin
					hits_q <= hits_q + DMPCT_PAGE_W'(1);
				end
				if (inc_miss) begin
					misses_q <= misses_q + DMPCT_PAGE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= opcode;
			page_s1 <= page_number;
			prod_s1 <= 65'(page_number) * 65'(RECIP);
		end
		if (adv_s1) begin
			op_s2       <= op_s1;
			page_s2     <= page_s1;
			idx_s2      <= addr_s1;
			fwd_line_s2 <= new_line;
		end
		if (cfg_acc) begin
			pt_prod_q <= 65'(pages_at_open) * 65'(RECIP);
		end
		if (adv_s2) begin
			status_q     <= st;
			hit_q        <= h;
			fetch_q      <= fetch;
			wb_q         <= wb;
			evict_page_q <= wb ? line_cur.tag : '0;
			target_q     <= tgt;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign hit             = hit_q;
	assign fetch_needed    = fetch_q;
	assign evict_writeback = wb_q;
	assign evict_page      = evict_page_q;
	assign target_page     = target_q;
	assign page_count_now  = page_total_q;
	assign read_count      = reads_q;
	assign write_count     = writes_q;
	assign append_count    = appends_q;
	assign hit_total       = hits_q;
	assign miss_total      = misses_q;

endmodule

`default_nettype wire
